// ===== hw/rtl/sslp_pkg.sv =====
// ============================================================================
// sslp_pkg
// Shared types, codes and the version text for the status line parser.
// ============================================================================
package sslp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 10;
    localparam int unsigned KindW  = 2;
    localparam int unsigned ErrW   = 3;
    localparam int unsigned VidxW  = 3;
    localparam int unsigned CountW = 3;

    // Number of characters in "SIP/2.0".
    localparam logic [VidxW-1:0] VersionLen = VidxW'(7);
    localparam logic [CountW-1:0] CodeDigits = CountW'(3);
    localparam logic [CodeW-1:0] MaxCode    = CodeW'(999);

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_VERSION = 3'd1,
        PH_CODE    = 3'd2,
        PH_SPACES  = 3'd3,
        PH_DESC    = 3'd4,
        PH_DRAIN   = 3'd5
    } t_phase;

    localparam logic [KindW-1:0] KIND_DESC  = KindW'(0);
    localparam logic [KindW-1:0] KIND_DONE  = KindW'(1);
    localparam logic [KindW-1:0] KIND_ERROR = KindW'(2);

    localparam logic [ErrW-1:0] ERR_NONE    = ErrW'(0);
    localparam logic [ErrW-1:0] ERR_VERSION = ErrW'(1);
    localparam logic [ErrW-1:0] ERR_SHORT   = ErrW'(2);
    localparam logic [ErrW-1:0] ERR_NOCODE  = ErrW'(3);
    localparam logic [ErrW-1:0] ERR_UNTERM  = ErrW'(4);

    localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
    localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
    localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
    localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
    localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
    localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic             valid;
        logic [KindW-1:0] kind;
        logic [CodeW-1:0] status_code;
        logic [ByteW-1:0] desc_byte;
        logic [ErrW-1:0]  error_code;
    } t_result;

    function automatic logic [ByteW-1:0] version_char(input logic [VidxW-1:0] idx);
        logic [ByteW-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h53; // S
            3'd1:    ch = 8'h49; // I
            3'd2:    ch = 8'h50; // P
            3'd3:    ch = 8'h2F; // /
            3'd4:    ch = 8'h32; // 2
            3'd5:    ch = 8'h2E; // .
            3'd6:    ch = 8'h30; // 0
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/sslp_core.sv =====
// ============================================================================
// sslp_core
// Parser state and the per-byte step logic; the state advances on i_step.
// ============================================================================
module sslp_core
    import sslp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_last_byte,
    output t_result          o_result
);

    t_phase             r_phase,  n_phase;
    logic [VidxW-1:0]   r_vidx,   n_vidx;
    logic [CodeW-1:0]   r_acc,    n_acc;
    logic [CountW-1:0]  r_cnt,    n_cnt;
    logic               r_bad,    n_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_vidx  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_bad   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_vidx  <= n_vidx;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_bad   <= n_bad;
        end
    end

    always_comb begin
        logic             is_ws;
        logic             is_digit;
        logic             is_eol;
        logic             do_version;
        logic             do_desc;
        logic             fin;
        logic             clear;
        logic [KindW-1:0] fin_kind;
        logic [ErrW-1:0]  fin_err;
        logic [VidxW-1:0] vidx_eff;

        is_ws    = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
        is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        is_eol   = (i_data_byte == CH_CR) || (i_data_byte == CH_LF);

        n_phase    = r_phase;
        n_vidx     = r_vidx;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_bad      = r_bad;
        o_result   = '0;
        do_version = 1'b0;
        do_desc    = 1'b0;
        fin        = 1'b0;
        clear      = 1'b0;
        fin_kind   = KIND_ERROR;
        fin_err    = ERR_NONE;
        vidx_eff   = r_vidx;

        unique case (r_phase)
            PH_LEAD: begin
                if (is_ws || is_eol) begin
                    if (i_last_byte) begin
                        fin     = 1'b1;
                        fin_err = ERR_VERSION;
                    end
                end else begin
                    // This byte is already the first version character.
                    do_version = 1'b1;
                    vidx_eff   = '0;
                end
            end
            PH_VERSION: begin
                do_version = 1'b1;
            end
            PH_CODE: begin
                if (r_cnt == '0 && is_ws) begin
                    if (i_last_byte) begin
                        fin     = 1'b1;
                        fin_err = ERR_SHORT;
                    end
                end else begin
                    if (is_digit) begin
                        n_acc = r_acc * CodeW'(10) + {{(CodeW-4){1'b0}}, i_data_byte[3:0]};
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_cnt = r_cnt + CountW'(1);
                    if (i_last_byte) begin
                        fin     = 1'b1;
                        fin_err = ERR_SHORT;
                    end else if (n_cnt >= CodeDigits) begin
                        n_phase = PH_SPACES;
                    end
                end
            end
            PH_SPACES: begin
                if (r_bad) begin
                    fin     = 1'b1;
                    fin_err = ERR_NOCODE;
                end else if (i_data_byte == CH_SPACE) begin
                    if (i_last_byte) begin
                        fin     = 1'b1;
                        fin_err = ERR_UNTERM;
                    end
                end else begin
                    do_desc = 1'b1;
                end
            end
            PH_DESC: begin
                do_desc = 1'b1;
            end
            default: begin
                clear = i_last_byte;
            end
        endcase

        if (do_version) begin
            n_vidx = vidx_eff;
            if (vidx_eff >= VersionLen || i_data_byte != version_char(vidx_eff)) begin
                n_phase = PH_VERSION;
                fin     = 1'b1;
                fin_err = ERR_VERSION;
            end else begin
                n_vidx  = vidx_eff + VidxW'(1);
                n_phase = PH_VERSION;
                if (n_vidx == VersionLen) begin
                    n_phase = PH_CODE;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_bad   = 1'b0;
                    if (i_last_byte) begin
                        fin     = 1'b1;
                        fin_err = ERR_SHORT;
                    end
                end else if (i_last_byte) begin
                    fin     = 1'b1;
                    fin_err = ERR_VERSION;
                end
            end
        end

        if (do_desc) begin
            n_phase = PH_DESC;
            if (is_eol) begin
                fin      = 1'b1;
                fin_kind = KIND_DONE;
            end else if (i_last_byte) begin
                fin     = 1'b1;
                fin_err = ERR_UNTERM;
            end else begin
                o_result.valid     = 1'b1;
                o_result.kind      = KIND_DESC;
                o_result.desc_byte = i_data_byte;
            end
        end

        if (fin) begin
            o_result.valid      = 1'b1;
            o_result.kind       = fin_kind;
            o_result.error_code = fin_err;
            if (fin_kind == KIND_DONE) begin
                o_result.status_code = r_acc;
            end
            n_phase = PH_DRAIN;
            clear   = i_last_byte;
        end

        // The byte marked last always leaves the parser ready for a new message.
        if (clear) begin
            n_phase = PH_LEAD;
            n_vidx  = '0;
            n_acc   = '0;
            n_cnt   = '0;
            n_bad   = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/sip_status_line_parser.sv =====
// ============================================================================
// sip_status_line_parser
// Parses the status line of a SIP response, one message byte per transaction.
// ============================================================================
//  Channel  Direction  Handshake                 Payload
//  input    in         i_in_valid / o_in_ready   i_data_byte, i_last_byte
//  output   out        o_out_valid / i_out_ready o_kind, o_status_code,
//                                                o_desc_byte, o_error_code
//
// One byte is accepted per cycle while the output is not stalled. A byte is
// captured in the input register, parsed there and its result registered in
// the output. Bytes that cause no result leave the output untouched.
// Reset is synchronous and returns the parser to leading whitespace skip.
// A stalled output holds its result; the input register then fills and
// o_in_ready drops until the output is taken.
// ============================================================================
module sip_status_line_parser
    import sslp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_last_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [KindW-1:0] o_kind,
    output logic [CodeW-1:0] o_status_code,
    output logic [ByteW-1:0] o_desc_byte,
    output logic [ErrW-1:0]  o_error_code
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    t_result          r_out;
    t_result          w_result;
    logic             w_step;

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    sslp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_status_code = r_out.status_code;
    assign o_desc_byte   = r_out.desc_byte;
    assign o_error_code  = r_out.error_code;

endmodule

// ===== hw/rtl/sslp_checker.sv =====
// ============================================================================
// sslp_checker
// Port-level checks on the result stream of the status line parser.
// ============================================================================
module sslp_checker
    import sslp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [KindW-1:0] o_kind,
    input logic [CodeW-1:0] o_status_code,
    input logic [ByteW-1:0] o_desc_byte,
    input logic [ErrW-1:0]  o_error_code
);

    // A description byte carries no code and no error.
    a_desc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DESC |->
            o_status_code == '0 && o_error_code == ERR_NONE)
        else $error("description transaction carries a code or an error");

    // A done result carries a three-digit code and nothing else.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE |->
            o_status_code <= MaxCode && o_error_code == ERR_NONE && o_desc_byte == '0)
        else $error("done transaction is malformed");

    // An error result names a real error and carries no code or byte.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERROR |->
            o_error_code != ERR_NONE && o_error_code <= ERR_UNTERM &&
            o_status_code == '0 && o_desc_byte == '0)
        else $error("error transaction is malformed");

    // Only the three defined kinds ever leave the block.
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind == KIND_DESC || o_kind == KIND_DONE || o_kind == KIND_ERROR)
        else $error("undefined result kind");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_status_code) &&
            $stable(o_desc_byte) && $stable(o_error_code))
        else $error("stalled output transaction changed");

endmodule

bind sip_status_line_parser sslp_checker u_sslp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_status_code (o_status_code),
    .o_desc_byte   (o_desc_byte),
    .o_error_code  (o_error_code)
);
